/* rtl/core/intruder_alarm_sequencer_core_defines.svh */
// Assertion macros shared by the intruder alarm sequencer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef INTRUDER_ALARM_SEQUENCER_CORE_DEFINES_SVH
`define INTRUDER_ALARM_SEQUENCER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define IAS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ias check failed");

// Next-cycle implication, disabled while reset is held.
`define IAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ias check failed");

`endif

/* rtl/core/ias_pkg.sv */
// Package for the intruder alarm sequencer: mode codes, LED bit positions,
// register indexes, reset values and the config/result structs. No dependencies.
package ias_pkg;

  localparam int IAS_TIMER_WIDTH = 16;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_ARMING  = 3'd1,
    MODE_ARMED   = 3'd2,
    MODE_TRIG    = 3'd3,
    MODE_SOUND   = 3'd4,
    MODE_DISARM  = 3'd5
  } mode_t;

  // Bit positions in the latched drive vector
  localparam int LED_STATUS = 0;
  localparam int LED_ARMED  = 1;
  localparam int LED_BUZZ   = 2;

  // Register indexes on the config port
  localparam logic [2:0] CFG_BLINK_HALF   = 3'd0;
  localparam logic [2:0] CFG_ARM_BLINKS   = 3'd1;
  localparam logic [2:0] CFG_TRIG_ROUNDS  = 3'd2;
  localparam logic [2:0] CFG_SOUND_STEP   = 3'd3;
  localparam logic [2:0] CFG_SOUND_ROUNDS = 3'd4;
  localparam logic [2:0] CFG_DISARM_WAIT  = 3'd5;

  // Reset values
  localparam logic [15:0] RST_BLINK_HALF   = 16'd100;
  localparam logic [7:0]  RST_ARM_BLINKS   = 8'd11;
  localparam logic [7:0]  RST_TRIG_ROUNDS  = 8'd11;
  localparam logic [15:0] RST_SOUND_STEP   = 16'd200;
  localparam logic [7:0]  RST_SOUND_ROUNDS = 8'd3;
  localparam logic [15:0] RST_DISARM_WAIT  = 16'd1000;

  typedef struct packed {
    logic [15:0] blink_half_ms;
    logic [7:0]  arming_blinks;
    logic [7:0]  trigger_rounds;
    logic [15:0] sound_step_ms;
    logic [7:0]  sound_rounds;
    logic [15:0] disarm_wait_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0] leds;
    logic       notify;
    mode_t      mode;
  } result_t;

endpackage

/* rtl/core/ias_fsm.sv */
// Mode machine of the intruder alarm sequencer: state registers and the
// one-tick update. Depends on ias_pkg.
module ias_fsm import ias_pkg::*; #(
  parameter int TIMER_WIDTH = IAS_TIMER_WIDTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  logic    sensor,
  input  logic    button_n,
  input  cfg_t    cfg,
  output result_t res
);

  localparam int CW = ((TIMER_WIDTH > 16) ? TIMER_WIDTH : 16) + 1;

  mode_t                   mode_r, mode_nxt;
  logic [TIMER_WIDTH-1:0]  timer_r, timer_nxt;
  logic [7:0]              round_r, round_nxt;
  logic [1:0]              phase_r, phase_nxt;
  logic [2:0]              led_r, led_nxt;
  logic                    notify;

  logic [15:0]             len;
  logic                    done;
  logic                    pressed;
  logic                    go_disarm;
  logic [7:0]              round_inc;
  logic [TIMER_WIDTH-1:0]  timer_inc;

  assign pressed   = ~button_n;
  assign round_inc = round_r + 8'd1;
  assign timer_inc = timer_r + {{(TIMER_WIDTH-1){1'b0}}, 1'b1};

  always_comb begin
    case (mode_r)
      MODE_ARMING, MODE_TRIG: len = cfg.blink_half_ms;
      MODE_SOUND:             len = cfg.sound_step_ms;
      default:                len = cfg.disarm_wait_ms;
    endcase
  end

  // Last tick of a phase; saturated timer ends it too
  assign done = (CW'(timer_r) + CW'(1) >= CW'(len)) || (&timer_r);

  always_comb begin
    mode_nxt  = mode_r;
    timer_nxt = timer_r;
    round_nxt = round_r;
    phase_nxt = phase_r;
    led_nxt   = led_r;
    notify    = 1'b0;
    go_disarm = 1'b0;

    case (mode_r)
      MODE_ARMING: begin
        timer_nxt = done ? '0 : timer_inc;
        if (done) begin
          if (phase_r == 2'd0) begin
            phase_nxt           = 2'd1;
            led_nxt[LED_STATUS] = 1'b0;
          end else begin
            round_nxt = round_inc;
            phase_nxt = 2'd0;
            if (round_inc >= cfg.arming_blinks) begin
              led_nxt[LED_ARMED]  = 1'b1;
              led_nxt[LED_STATUS] = 1'b0;
              mode_nxt            = MODE_ARMED;
            end else begin
              led_nxt[LED_STATUS] = 1'b1;
            end
          end
        end
      end
      MODE_ARMED: begin
        if (sensor) begin
          mode_nxt            = MODE_TRIG;
          timer_nxt           = '0;
          round_nxt           = '0;
          phase_nxt           = 2'd0;
          led_nxt[LED_STATUS] = 1'b1;
        end else if (pressed) begin
          go_disarm = 1'b1;
        end
      end
      MODE_TRIG: begin
        timer_nxt = done ? '0 : timer_inc;
        if (done) begin
          case (phase_r)
            2'd0: begin
              led_nxt[LED_ARMED] = 1'b1;
              phase_nxt          = 2'd1;
            end
            2'd1: begin
              led_nxt[LED_STATUS] = 1'b0;
              phase_nxt           = 2'd2;
            end
            2'd2: begin
              led_nxt[LED_ARMED] = 1'b0;
              phase_nxt          = 2'd3;
            end
            default: begin
              if (pressed) begin
                go_disarm = 1'b1;
              end else begin
                round_nxt = round_inc;
                phase_nxt = 2'd0;
                if (round_inc >= cfg.trigger_rounds) begin
                  mode_nxt          = MODE_SOUND;
                  round_nxt         = '0;
                  led_nxt[LED_BUZZ] = 1'b1;
                end else begin
                  led_nxt[LED_STATUS] = 1'b1;
                end
              end
            end
          endcase
        end
      end
      MODE_SOUND: begin
        timer_nxt = done ? '0 : timer_inc;
        if (done) begin
          case (phase_r)
            2'd0: begin
              led_nxt[LED_BUZZ]   = 1'b0;
              led_nxt[LED_STATUS] = 1'b1;
              phase_nxt           = 2'd1;
            end
            2'd1: begin
              led_nxt[LED_STATUS] = 1'b0;
              led_nxt[LED_ARMED]  = 1'b1;
              phase_nxt           = 2'd2;
            end
            default: begin
              led_nxt[LED_ARMED] = 1'b0;
              phase_nxt          = 2'd0;
              round_nxt          = round_inc;
              if (round_inc >= cfg.sound_rounds) begin
                notify    = 1'b1;
                round_nxt = '0;
                if (pressed) begin
                  go_disarm = 1'b1;
                end else begin
                  mode_nxt = MODE_ARMED;
                end
              end else begin
                led_nxt[LED_BUZZ] = 1'b1;
              end
            end
          endcase
        end
      end
      MODE_DISARM: begin
        timer_nxt = done ? '0 : timer_inc;
        if (done) begin
          mode_nxt  = MODE_OFF;
          timer_nxt = '0;
          round_nxt = '0;
          phase_nxt = 2'd0;
          led_nxt   = 3'b001;
        end
      end
      default: begin
        led_nxt = 3'b001;
        if (mode_r != MODE_OFF || pressed) begin
          timer_nxt = '0;
          round_nxt = '0;
          phase_nxt = 2'd0;
        end
        mode_nxt = pressed ? MODE_ARMING : MODE_OFF;
      end
    endcase

    // Disarm entry; zero wait drops straight to off
    if (go_disarm) begin
      if (cfg.disarm_wait_ms == 16'd0) begin
        mode_nxt  = MODE_OFF;
        timer_nxt = '0;
        round_nxt = '0;
        phase_nxt = 2'd0;
        led_nxt   = 3'b001;
      end else begin
        mode_nxt  = MODE_DISARM;
        timer_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_OFF;
      timer_r <= '0;
      round_r <= '0;
      phase_r <= 2'd0;
      led_r   <= 3'b001;
    end else if (step) begin
      mode_r  <= mode_nxt;
      timer_r <= timer_nxt;
      round_r <= round_nxt;
      phase_r <= phase_nxt;
      led_r   <= led_nxt;
    end
  end

  assign res.leds   = led_nxt;
  assign res.notify = notify;
  assign res.mode   = mode_nxt;

endmodule

/* rtl/core/intruder_alarm_sequencer_core.sv */
// Intruder alarm sequencer: each input transaction is one millisecond tick
// (sensor level, active-low button level) and yields exactly one result
// transaction with the latched status LED, armed LED and buzzer levels, a
// one-tick notify pulse and the mode after that tick. A tick passes through
// an input register, one pass of the mode update logic and an output
// register; a new tick is taken every cycle while the output side keeps up;
// the output register holds a result under stall and the input register
// keeps the next tick. Config registers are written over the cfg_ port
// (always ready) and must only change while idle.
// Depends on ias_pkg and ias_fsm.
`include "intruder_alarm_sequencer_core_defines.svh"

module intruder_alarm_sequencer_core import ias_pkg::*; #(
  parameter int TIMER_WIDTH = IAS_TIMER_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // tick channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_sensor,
  input  logic        in_button_n,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_status_led,
  output logic        out_armed_led,
  output logic        out_buzzer,
  output logic        out_notify,
  output logic [2:0]  out_mode,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg_r;
  result_t res;
  result_t out_r;

  logic in_vld_r;
  logic in_sensor_r;
  logic in_button_n_r;
  logic out_vld_r;
  logic adv;
  logic in_take;

  // Config registers; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blink_half_ms  <= RST_BLINK_HALF;
      cfg_r.arming_blinks  <= RST_ARM_BLINKS;
      cfg_r.trigger_rounds <= RST_TRIG_ROUNDS;
      cfg_r.sound_step_ms  <= RST_SOUND_STEP;
      cfg_r.sound_rounds   <= RST_SOUND_ROUNDS;
      cfg_r.disarm_wait_ms <= RST_DISARM_WAIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLINK_HALF:   cfg_r.blink_half_ms  <= cfg_data;
        CFG_ARM_BLINKS:   cfg_r.arming_blinks  <= cfg_data[7:0];
        CFG_TRIG_ROUNDS:  cfg_r.trigger_rounds <= cfg_data[7:0];
        CFG_SOUND_STEP:   cfg_r.sound_step_ms  <= cfg_data;
        CFG_SOUND_ROUNDS: cfg_r.sound_rounds   <= cfg_data[7:0];
        CFG_DISARM_WAIT:  cfg_r.disarm_wait_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Tick moves from input register to output register when there is room
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_sensor_r   <= in_sensor;
      in_button_n_r <= in_button_n;
    end
  end

  ias_fsm #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_fsm (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (adv),
    .sensor   (in_sensor_r),
    .button_n (in_button_n_r),
    .cfg      (cfg_r),
    .res      (res)
  );

  // Output register, held while the consumer stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_status_led = out_r.leds[LED_STATUS];
  assign out_armed_led  = out_r.leds[LED_ARMED];
  assign out_buzzer     = out_r.leds[LED_BUZZ];
  assign out_notify     = out_r.notify;
  assign out_mode       = out_r.mode;

  // Notify only fires on the tick sounding ends, which lands in armed, disarm or off
  `IAS_ASSERT_IMPLY(a_notify_exit, clk, rst_n, out_vld_r && out_r.notify, out_r.mode == MODE_ARMED || out_r.mode == MODE_DISARM || out_r.mode == MODE_OFF)
  // Buzzer is only ever driven while sounding
  `IAS_ASSERT_IMPLY(a_buzz_sound, clk, rst_n, out_vld_r && out_r.leds[LED_BUZZ], out_r.mode == MODE_SOUND)
  // Off mode always shows status LED alone
  `IAS_ASSERT_IMPLY(a_off_leds, clk, rst_n, out_vld_r && out_r.mode == MODE_OFF, out_r.leds == 3'b001)
  // A tick that advances always shows up as a result next cycle
  `IAS_ASSERT_NEXT(a_adv_out, clk, rst_n, adv, out_vld_r)

endmodule
